FILE: hw/rtl/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, constants and the hex digit decoder for the escape string
// decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    // Longest string length that the byte count tracks before it saturates.
    localparam int MAX_LEN = 4096;
    localparam int COUNT_W = $clog2(MAX_LEN + 1);

    // Width of the decoded count as it is reported on the result word.
    localparam int OUT_COUNT_W = 13;

    // Character codes.
    localparam logic [7:0] ESC_CHAR = 8'h5C;
    localparam logic [3:0] NIB_MASK = 4'hF;

    // Escape tracking state; the unused code behaves as idle.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_HEX  = 2'd2
    } phase_t;

    // Status codes carried on each result word.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_END_ESC  = 2'd1,
        ST_NO_DIGIT = 2'd2,
        ST_BAD_HEX  = 2'd3
    } status_t;

    // What one character does to the decoder.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_OPEN,
        ACT_FIRST,
        ACT_BYTE,
        ACT_ERROR,
        ACT_DROP
    } action_t;

    // One input character as held in the input register.
    typedef struct packed {
        logic [7:0] in_char;
        logic       is_last;
    } char_t;

    // One result word.
    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   byte_valid;
        status_t                status;
        logic                   done_res;
        logic [OUT_COUNT_W-1:0] decoded_count;
    } result_t;

    // Hex digit value in the low four bits; bit 4 set when not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h61 + 8'd10)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h41 + 8'd10)};
        end
        return v;
    endfunction

endpackage

FILE: hw/rtl/escape_string_decoder.sv
// ----------------------------------------------------------------------------
// escape_string_decoder
// Streaming decoder for backslash and two-digit hex escapes, one character
// per word, with byte counting and error reporting per string.
// ----------------------------------------------------------------------------
// The block takes one character word per cycle and sustains that rate while
// the output side keeps up. An accepted word is held in an input register,
// decoded combinationally against the escape state register, and the result
// lands in an output register once that register is free, from where it can
// be taken. Characters that open an escape, first hex digits and characters
// dropped after an error give no output word. The decode loop through the
// escape state register is what sets the one-word-a-cycle figure; a stalled
// output register holds back the input register and then s_tready.
module escape_string_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_char[7:0]
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_byte[7:0], status[9:8],
                                   // decoded_count[22:10], zero pad[23]
    output logic        m_tuser,   // byte_valid
    output logic        m_tlast    // done_res
);

    logic             in_valid_reg;
    esd_pkg::char_t   in_data_reg;
    logic             out_valid_reg;
    esd_pkg::result_t out_data_reg;

    logic             out_free;
    logic             step;
    logic             res_valid;
    esd_pkg::result_t res;

    // The input word is consumed once the output register can take a result.
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            in_data_reg.in_char <= s_tdata;
            in_data_reg.is_last <= s_tlast;
        end
    end

    esd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cur       (in_data_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg.decoded_count, out_data_reg.status,
                       out_data_reg.out_byte};
    assign m_tuser  = out_data_reg.byte_valid;
    assign m_tlast  = out_data_reg.done_res;

    // A word carrying a byte always reports good status.
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[9:8] == esd_pkg::ST_OK))
        else $error("byte word with error status");

    // An error word ends the string and carries no byte.
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[9:8] != esd_pkg::ST_OK) |-> (m_tlast && !m_tuser))
        else $error("error word not final or carries a byte");

    // The count never passes its saturation value.
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[22:10] <= esd_pkg::OUT_COUNT_W'(esd_pkg::MAX_LEN)))
        else $error("decoded count above saturation");

    // A held input word stays put until it is consumed.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("input register lost a word");

endmodule

FILE: hw/rtl/esd_core.sv
// ----------------------------------------------------------------------------
// esd_core
// Escape tracking state machine: decodes the character in the input register
// against the string state and updates that state when the word is consumed.
// ----------------------------------------------------------------------------
module esd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  esd_pkg::char_t   cur,
    output logic             res_valid,
    output esd_pkg::result_t res
);

    esd_pkg::phase_t               phase_reg, phase_next;
    logic [3:0]                    high_nibble_reg, high_nibble_next;
    logic                          high_ok_reg, high_ok_next;
    logic [esd_pkg::COUNT_W-1:0]   byte_count_reg, byte_count_next;
    logic                          discarding_reg, discarding_next;

    esd_pkg::action_t              action;
    esd_pkg::status_t              err_status;
    logic [7:0]                    dec_byte;
    logic [4:0]                    hex;
    logic [esd_pkg::COUNT_W-1:0]   count_inc;

    assign hex = esd_pkg::hex_value(cur.in_char);

    // Saturating increment of the byte count.
    assign count_inc = (byte_count_reg < esd_pkg::COUNT_W'(esd_pkg::MAX_LEN))
                     ? byte_count_reg + 1'b1 : byte_count_reg;

    // Classify the current character.
    always_comb
    begin
        action     = esd_pkg::ACT_NONE;
        err_status = esd_pkg::ST_OK;
        dec_byte   = cur.in_char;
        if (discarding_reg) begin
            action = esd_pkg::ACT_DROP;
        end else begin
            case (phase_reg)
                esd_pkg::PH_ESC:
                begin
                    if (cur.in_char == esd_pkg::ESC_CHAR) begin
                        action   = esd_pkg::ACT_BYTE;
                        dec_byte = esd_pkg::ESC_CHAR;
                    end else if (cur.is_last) begin
                        action     = esd_pkg::ACT_ERROR;
                        err_status = esd_pkg::ST_NO_DIGIT;
                    end else begin
                        action = esd_pkg::ACT_FIRST;
                    end
                end
                esd_pkg::PH_HEX:
                begin
                    if (!high_ok_reg || hex[4]) begin
                        action     = esd_pkg::ACT_ERROR;
                        err_status = esd_pkg::ST_BAD_HEX;
                    end else begin
                        action   = esd_pkg::ACT_BYTE;
                        dec_byte = {high_nibble_reg, hex[3:0]};
                    end
                end
                default:
                begin
                    if (cur.in_char == esd_pkg::ESC_CHAR) begin
                        if (cur.is_last) begin
                            action     = esd_pkg::ACT_ERROR;
                            err_status = esd_pkg::ST_END_ESC;
                        end else begin
                            action = esd_pkg::ACT_OPEN;
                        end
                    end else begin
                        action = esd_pkg::ACT_BYTE;
                    end
                end
            endcase
        end
    end

    // Next string state.
    always_comb
    begin
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        high_ok_next     = high_ok_reg;
        byte_count_next  = byte_count_reg;
        discarding_next  = discarding_reg;
        case (action)
            esd_pkg::ACT_DROP:
            begin
                if (cur.is_last) begin
                    discarding_next  = 1'b0;
                    phase_next       = esd_pkg::PH_IDLE;
                    high_nibble_next = 4'h0;
                    high_ok_next     = 1'b0;
                    byte_count_next  = '0;
                end
            end
            esd_pkg::ACT_OPEN:
            begin
                phase_next = esd_pkg::PH_ESC;
            end
            esd_pkg::ACT_FIRST:
            begin
                phase_next       = esd_pkg::PH_HEX;
                high_ok_next     = !hex[4];
                high_nibble_next = hex[3:0] & esd_pkg::NIB_MASK;
            end
            esd_pkg::ACT_BYTE:
            begin
                phase_next      = esd_pkg::PH_IDLE;
                byte_count_next = count_inc;
                if (cur.is_last) begin
                    high_nibble_next = 4'h0;
                    high_ok_next     = 1'b0;
                    byte_count_next  = '0;
                end
            end
            esd_pkg::ACT_ERROR:
            begin
                phase_next       = esd_pkg::PH_IDLE;
                high_nibble_next = 4'h0;
                high_ok_next     = 1'b0;
                byte_count_next  = '0;
                discarding_next  = !cur.is_last;
            end
            default:
            begin
            end
        endcase
    end

    // Result word for the current character.
    always_comb
    begin
        res_valid          = 1'b0;
        res.out_byte       = 8'h00;
        res.byte_valid     = 1'b0;
        res.status         = esd_pkg::ST_OK;
        res.done_res       = 1'b0;
        res.decoded_count  = esd_pkg::OUT_COUNT_W'(byte_count_reg);
        case (action)
            esd_pkg::ACT_BYTE:
            begin
                res_valid         = 1'b1;
                res.out_byte      = dec_byte;
                res.byte_valid    = 1'b1;
                res.done_res      = cur.is_last;
                res.decoded_count = esd_pkg::OUT_COUNT_W'(count_inc);
            end
            esd_pkg::ACT_ERROR:
            begin
                res_valid    = 1'b1;
                res.status   = err_status;
                res.done_res = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // String state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= esd_pkg::PH_IDLE;
            high_nibble_reg <= 4'h0;
            high_ok_reg     <= 1'b0;
            byte_count_reg  <= '0;
            discarding_reg  <= 1'b0;
        end else if (step) begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            high_ok_reg     <= high_ok_next;
            byte_count_reg  <= byte_count_next;
            discarding_reg  <= discarding_next;
        end
    end

endmodule

FILE: sim/escape_string_decoder_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_string_decoder_check
// Watches both stream channels of the escape string decoder, predicts each
// result word from the accepted characters and compares it with the word
// that the block delivers.
// ----------------------------------------------------------------------------
module escape_string_decoder_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_char[7:0]
    input  logic        s_tlast,   // is_last
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // out_byte[7:0], status[9:8],
                                   // decoded_count[22:10], zero pad[23]
    input  logic        m_tuser,   // byte_valid
    input  logic        m_tlast,   // done_res
    output int          mismatches,
    output int          words_due,
    output int          words_seen,
    output int          errors_seen
);

    // Decoder state as the checker tracks it.
    esd_pkg::phase_t  esc_phase;
    logic [3:0]       hi_nib;
    bit               hi_valid;
    int unsigned      str_len;
    bit               dropping;

    // Result words still to come, oldest first.
    esd_pkg::result_t due_words[$];

    initial
    begin
        esc_phase   = esd_pkg::PH_IDLE;
        hi_nib      = '0;
        hi_valid    = 1'b0;
        str_len     = 0;
        dropping    = 1'b0;
        mismatches  = 0;
        words_due   = 0;
        words_seen  = 0;
        errors_seen = 0;
    end

    // Value of a hex digit in the low four bits, bit 4 set for any other
    // character. Letters of either case share their low nibble.
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]}) begin
            return {1'b0, c[3:0]};
        end
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    function automatic void clear_string();
        esc_phase = esd_pkg::PH_IDLE;
        hi_nib    = '0;
        hi_valid  = 1'b0;
        str_len   = 0;
    endfunction

    // A decoded byte; the length saturates at the longest tracked string.
    function automatic void push_byte(input logic [7:0] b, input bit last);
        esd_pkg::result_t w;
        if (str_len < esd_pkg::MAX_LEN) begin
            str_len++;
        end
        esc_phase       = esd_pkg::PH_IDLE;
        w.out_byte      = b;
        w.byte_valid    = 1'b1;
        w.status        = esd_pkg::ST_OK;
        w.done_res      = last;
        w.decoded_count = str_len[esd_pkg::OUT_COUNT_W-1:0];
        due_words.push_back(w);
        if (last) begin
            clear_string();
        end
    endfunction

    // An error closes the string; the rest of it is dropped unless the
    // error fell on its last character.
    function automatic void push_error(input esd_pkg::status_t st, input bit last);
        esd_pkg::result_t w;
        w.out_byte      = '0;
        w.byte_valid    = 1'b0;
        w.status        = st;
        w.done_res      = 1'b1;
        w.decoded_count = str_len[esd_pkg::OUT_COUNT_W-1:0];
        due_words.push_back(w);
        errors_seen++;
        clear_string();
        dropping = !last;
    endfunction

    // Works out what one accepted character does to the decoder.
    function automatic void decode_char(input logic [7:0] c, input bit last);
        logic [4:0] v;
        if (dropping) begin
            if (last) begin
                dropping = 1'b0;
                clear_string();
            end
            return;
        end
        case (esc_phase)
            esd_pkg::PH_ESC:
            begin
                if (c == esd_pkg::ESC_CHAR) begin
                    push_byte(esd_pkg::ESC_CHAR, last);
                end else if (last) begin
                    push_error(esd_pkg::ST_NO_DIGIT, 1'b1);
                end else begin
                    v         = digit_value(c);
                    hi_valid  = !v[4];
                    hi_nib    = v[3:0];
                    esc_phase = esd_pkg::PH_HEX;
                end
            end
            esd_pkg::PH_HEX:
            begin
                v = digit_value(c);
                if (!hi_valid || v[4]) begin
                    push_error(esd_pkg::ST_BAD_HEX, last);
                end else begin
                    push_byte({hi_nib, v[3:0]}, last);
                end
            end
            default:
            begin
                if (c != esd_pkg::ESC_CHAR) begin
                    push_byte(c, last);
                end else if (last) begin
                    push_error(esd_pkg::ST_END_ESC, 1'b1);
                end else begin
                    esc_phase = esd_pkg::PH_ESC;
                end
            end
        endcase
    endfunction

    // Output words are checked before the character of the same edge is
    // decoded; a character cannot give its result at the edge that takes it.
    always @(posedge clk)
    begin
        esd_pkg::result_t got;
        esd_pkg::result_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got.out_byte      = m_tdata[7:0];
                got.byte_valid    = m_tuser;
                got.status        = esd_pkg::status_t'(m_tdata[9:8]);
                got.done_res      = m_tlast;
                got.decoded_count = m_tdata[22:10];
                words_seen++;
                if (due_words.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: result word %0d arrived with none expected: %06h",
                                 $realtime, words_seen, m_tdata);
                    end
                    mismatches++;
                end else begin
                    want = due_words.pop_front();
                    if (got.out_byte !== want.out_byte
                        || got.byte_valid !== want.byte_valid
                        || got.status !== want.status
                        || got.done_res !== want.done_res
                        || got.decoded_count !== want.decoded_count
                        || m_tdata[23] !== 1'b0) begin
                        if (mismatches < 10) begin
                            $display({"%0t: result word %0d: expected byte %02h valid %0b ",
                                      "status %0d done %0b count %0d, got byte %02h ",
                                      "valid %0b status %0d done %0b count %0d pad %0b"},
                                     $realtime, words_seen, want.out_byte,
                                     want.byte_valid, want.status, want.done_res,
                                     want.decoded_count, got.out_byte, got.byte_valid,
                                     m_tdata[9:8], got.done_res, got.decoded_count,
                                     m_tdata[23]);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                decode_char(s_tdata, s_tlast);
            end
            words_due = due_words.size();
        end
    end

endmodule

FILE: sim/escape_string_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_string_decoder_test
// Feeds escaped strings to the decoder: a few hand-picked strings for the
// escape forms and each error, then random strings, mostly well formed,
// under changing idle patterns on both sides and one long output stall.
// ----------------------------------------------------------------------------
module escape_string_decoder_test;

    typedef logic [7:0] text_t[$];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // in_char[7:0]
    logic        s_tlast = 1'b0;   // is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // out_byte[7:0], status[9:8],
                                   // decoded_count[22:10], zero pad[23]
    logic        m_tuser;          // byte_valid
    logic        m_tlast;          // done_res

    int mismatches;
    int words_due;
    int words_seen;
    int errors_seen;

    // Idle chances in percent for each side, and the current load phase.
    int tx_idle = 19;
    int rx_idle = 70;
    int load_phase = 0;
    int chars_sent = 0;
    int strings_sent = 0;

    escape_string_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    escape_string_decoder_check i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .words_due   (words_due),
        .words_seen  (words_seen),
        .errors_seen (errors_seen)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard limit on the run; far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Output side: random stalls, and one long hold-off when the idle-free
    // phase starts so that the block fills and stalls its input.
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (load_phase == 2 && !held) begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    // Offers one character word and returns at the edge that takes it.
    task automatic send_char(input logic [7:0] c, input bit last);
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        chars_sent++;
    endtask

    task automatic send_string(input text_t s);
        foreach (s[i])
        begin
            send_char(s[i], i == s.size() - 1);
        end
        strings_sent++;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (c == esd_pkg::ESC_CHAR);
        return c;
    endfunction

    // A hex digit character for a nibble, letters in either case.
    function automatic logic [7:0] hex_digit(input int nib);
        if (nib < 10) begin
            return 8'(8'h30 + nib);
        end
        return 8'(($urandom_range(1) ? 8'h61 : 8'h41) + nib - 10);
    endfunction

    // Mostly well-formed escapes with random content, some noise, and a
    // few strings cut off or broken inside an escape.
    task automatic make_text(output text_t s);
        int n;
        int pick;
        s = {};
        n = $urandom_range(1, 12);
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                s.push_back(plain_char());
            end else if (pick < 68) begin
                s.push_back(esd_pkg::ESC_CHAR);
                s.push_back(esd_pkg::ESC_CHAR);
            end else if (pick < 93) begin
                s.push_back(esd_pkg::ESC_CHAR);
                s.push_back(hex_digit($urandom_range(15)));
                s.push_back(hex_digit($urandom_range(15)));
            end else begin
                s.push_back(8'($urandom_range(255)));
            end
        end
        pick = $urandom_range(99);
        if (pick < 5) begin
            s.push_back(esd_pkg::ESC_CHAR);
        end else if (pick < 9) begin
            s.push_back(esd_pkg::ESC_CHAR);
            s.push_back(hex_digit($urandom_range(15)));
        end else if (pick < 13) begin
            s.push_back(esd_pkg::ESC_CHAR);
            s.push_back(plain_char());
            s.push_back(hex_digit($urandom_range(15)));
            s.push_back(plain_char());
        end
    endtask

    initial
    begin
        text_t s;
        int    target;
        wait (rst_n);
        @(posedge clk);

        // Hand-picked strings: extreme bytes, both escape forms, every error
        // and the dropping of characters after an error.
        s = '{8'h00, 8'hFF};
        send_string(s);
        s = '{esd_pkg::ESC_CHAR, esd_pkg::ESC_CHAR};
        send_string(s);
        s = '{esd_pkg::ESC_CHAR, 8'h34, 8'h31, esd_pkg::ESC_CHAR, 8'h66, 8'h46};
        send_string(s);
        s = '{esd_pkg::ESC_CHAR};
        send_string(s);
        s = '{esd_pkg::ESC_CHAR, 8'h37};
        send_string(s);
        s = '{esd_pkg::ESC_CHAR, 8'h47, 8'h31, 8'h78, 8'h79};
        send_string(s);
        s = '{esd_pkg::ESC_CHAR, 8'h33, esd_pkg::ESC_CHAR};
        send_string(s);
        s = '{esd_pkg::ESC_CHAR, 8'h5A};
        send_string(s);

        // Random strings under three idle mixes.
        for (int ph = 0; ph < 3; ph++)
        begin
            load_phase = ph;
            tx_idle    = (ph == 0) ? 19 : (ph == 1) ? 70 : 0;
            rx_idle    = (ph == 0) ? 70 : (ph == 1) ? 19 : 0;
            target     = chars_sent + 605;
            while (chars_sent < target)
            begin
                make_text(s);
                send_string(s);
            end
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (words_due != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);

        $display("Sent %0d characters in %0d strings under three idle mixes and a long stall;",
                 chars_sent, strings_sent);
        $display("checked %0d result words, %0d of them error reports.",
                 words_seen, errors_seen);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
